// ----- hw/rtl/rrp_pkg.sv -----
// ----------------------------------------------------------------------------
// rrp_pkg
// Shared types and relocation type codes for the relocation patcher.
// ----------------------------------------------------------------------------
package rrp_pkg;

	// ELF RISC-V relocation type numbers handled by the block
	localparam logic [7:0] R_32            = 8'd1;
	localparam logic [7:0] R_64            = 8'd2;
	localparam logic [7:0] R_BRANCH        = 8'd16;
	localparam logic [7:0] R_JAL           = 8'd17;
	localparam logic [7:0] R_CALL          = 8'd18;
	localparam logic [7:0] R_CALL_PLT      = 8'd19;
	localparam logic [7:0] R_GOT_HI20      = 8'd20;
	localparam logic [7:0] R_PCREL_HI20    = 8'd23;
	localparam logic [7:0] R_PCREL_LO12_I  = 8'd24;
	localparam logic [7:0] R_PCREL_LO12_S  = 8'd25;
	localparam logic [7:0] R_HI20          = 8'd26;
	localparam logic [7:0] R_LO12_I        = 8'd27;
	localparam logic [7:0] R_LO12_S        = 8'd28;
	localparam logic [7:0] R_TPREL_LO12_S  = 8'd31;
	localparam logic [7:0] R_ADD8          = 8'd33;
	localparam logic [7:0] R_ADD16         = 8'd34;
	localparam logic [7:0] R_ADD32         = 8'd35;
	localparam logic [7:0] R_ADD64         = 8'd36;
	localparam logic [7:0] R_SUB8          = 8'd37;
	localparam logic [7:0] R_SUB16         = 8'd38;
	localparam logic [7:0] R_SUB32         = 8'd39;
	localparam logic [7:0] R_SUB64         = 8'd40;
	localparam logic [7:0] R_ALIGN         = 8'd43;
	localparam logic [7:0] R_RVC_BRANCH    = 8'd44;
	localparam logic [7:0] R_RVC_JUMP      = 8'd45;
	localparam logic [7:0] R_RELAX         = 8'd51;
	localparam logic [7:0] R_SUB6          = 8'd52;
	localparam logic [7:0] R_SET6          = 8'd53;
	localparam logic [7:0] R_SET8          = 8'd54;
	localparam logic [7:0] R_SET16         = 8'd55;
	localparam logic [7:0] R_SET32         = 8'd56;
	localparam logic [7:0] R_32_PCREL      = 8'd57;

	// patch operation classes
	typedef enum logic [4:0] {
		OP_W32,
		OP_W64,
		OP_U,
		OP_I,
		OP_S,
		OP_B,
		OP_J,
		OP_CB,
		OP_CJ,
		OP_CALL,
		OP_ADD,
		OP_SUB,
		OP_SUB6,
		OP_SET6,
		OP_SET,
		OP_NOP,
		OP_UNSUP
	} op_t;

	// access width for data operations
	typedef enum logic [1:0] {
		SZ_8,
		SZ_16,
		SZ_32,
		SZ_64
	} size_t;

	typedef struct packed {
		op_t   op;
		size_t sz;
	} dec_t;

	typedef struct packed {
		logic [63:0] new_bytes;
		logic [3:0]  bytes_written;
		logic        range_error;
		logic        unsupported;
	} res_t;

endpackage

// ----- hw/rtl/rrp_decode.sv -----
// ----------------------------------------------------------------------------
// rrp_decode
// Maps a relocation type number to a patch operation and access width.
// ----------------------------------------------------------------------------
module rrp_decode
	import rrp_pkg::*;
(
	input  logic [7:0] reloc_kind,
	output dec_t       dec
);

	// classify the relocation type
	always_comb begin
		dec.sz = SZ_32;
		unique case (reloc_kind)
			R_32, R_32_PCREL, R_SET32: dec.op = OP_W32;
			R_64:                       dec.op = OP_W64;
			R_GOT_HI20, R_PCREL_HI20, R_HI20: dec.op = OP_U;
			R_PCREL_LO12_I, R_LO12_I:   dec.op = OP_I;
			R_PCREL_LO12_S, R_LO12_S, R_TPREL_LO12_S: dec.op = OP_S;
			R_BRANCH:                   dec.op = OP_B;
			R_JAL:                      dec.op = OP_J;
			R_RVC_BRANCH:               dec.op = OP_CB;
			R_RVC_JUMP:                 dec.op = OP_CJ;
			R_CALL, R_CALL_PLT:         dec.op = OP_CALL;
			R_ADD8: begin
				dec.op = OP_ADD;
				dec.sz = SZ_8;
			end
			R_ADD16: begin
				dec.op = OP_ADD;
				dec.sz = SZ_16;
			end
			R_ADD32:                    dec.op = OP_ADD;
			R_ADD64: begin
				dec.op = OP_ADD;
				dec.sz = SZ_64;
			end
			R_SUB8: begin
				dec.op = OP_SUB;
				dec.sz = SZ_8;
			end
			R_SUB16: begin
				dec.op = OP_SUB;
				dec.sz = SZ_16;
			end
			R_SUB32:                    dec.op = OP_SUB;
			R_SUB64: begin
				dec.op = OP_SUB;
				dec.sz = SZ_64;
			end
			R_SUB6:                     dec.op = OP_SUB6;
			R_SET6:                     dec.op = OP_SET6;
			R_SET8: begin
				dec.op = OP_SET;
				dec.sz = SZ_8;
			end
			R_SET16: begin
				dec.op = OP_SET;
				dec.sz = SZ_16;
			end
			R_ALIGN, R_RELAX:           dec.op = OP_NOP;
			default:                    dec.op = OP_UNSUP;
		endcase
	end

endmodule

// ----- hw/rtl/rrp_patch.sv -----
// ----------------------------------------------------------------------------
// rrp_patch
// Builds the patched memory word, byte count and flags for one relocation.
// ----------------------------------------------------------------------------
module rrp_patch
	import rrp_pkg::*;
(
	input  dec_t        dec,
	input  logic [63:0] old_bytes,
	input  logic [31:0] value,
	output res_t        res
);

	function automatic logic [31:0] put_u(input logic [31:0] insn, input logic [31:0] v);
		logic [31:0] hi;
		hi = v + 32'h0000_0800;
		return {hi[31:12], insn[11:0]};
	endfunction

	function automatic logic [31:0] put_i(input logic [31:0] insn, input logic [31:0] v);
		return {v[11:0], insn[19:0]};
	endfunction

	function automatic logic [31:0] put_s(input logic [31:0] insn, input logic [31:0] v);
		return {v[11:5], insn[24:12], v[4:0], insn[6:0]};
	endfunction

	function automatic logic [31:0] put_b(input logic [31:0] insn, input logic [31:0] v);
		return {v[12], v[10:5], insn[24:12], v[4:1], v[11], insn[6:0]};
	endfunction

	function automatic logic [31:0] put_j(input logic [31:0] insn, input logic [31:0] v);
		return {v[20], v[10:1], v[11], v[19:12], insn[11:0]};
	endfunction

	function automatic logic [15:0] put_cb(input logic [15:0] insn, input logic [31:0] v);
		return {insn[15:13], v[8], v[4:3], insn[9:7], v[7:6], v[2:1], v[5], insn[1:0]};
	endfunction

	function automatic logic [15:0] put_cj(input logic [15:0] insn, input logic [31:0] v);
		return {insn[15:13], v[11], v[4], v[9:8], v[10], v[6], v[7], v[3:1], v[5],
			insn[1:0]};
	endfunction

	logic [63:0] sv;
	logic [63:0] sum;
	logic [63:0] diff;
	logic [63:0] wide;
	logic [63:0] mask;
	logic [3:0]  size_cnt;
	logic [31:0] w0;
	logic [31:0] w1;
	logic [5:0]  low6;
	logic        upper_ok;
	logic        fits9;
	logic        fits12;
	logic        fits13;
	logic        fits21;

	assign sv   = {{32{value[31]}}, value};
	assign sum  = old_bytes + sv;
	assign diff = old_bytes - sv;
	assign w0   = old_bytes[31:0];
	assign w1   = old_bytes[63:32];
	assign low6 = old_bytes[5:0] - value[5:0];

	// signed range checks: upper bits must all match the sign
	assign fits9  = (&value[31:8])  | ~(|value[31:8]);
	assign fits12 = (&value[31:11]) | ~(|value[31:11]);
	assign fits13 = (&value[31:12]) | ~(|value[31:12]);
	assign fits21 = (&value[31:20]) | ~(|value[31:20]);
	// value + 0x800 overflows only from 0x7FFFF800 up to 0x7FFFFFFF
	assign upper_ok = value[31] | ~(&value[30:11]);

	// byte mask and count for data widths
	always_comb begin
		unique case (dec.sz)
			SZ_8: begin
				mask     = 64'h0000_0000_0000_00FF;
				size_cnt = 4'd1;
			end
			SZ_16: begin
				mask     = 64'h0000_0000_0000_FFFF;
				size_cnt = 4'd2;
			end
			SZ_32: begin
				mask     = 64'h0000_0000_FFFF_FFFF;
				size_cnt = 4'd4;
			end
			SZ_64: begin
				mask     = 64'hFFFF_FFFF_FFFF_FFFF;
				size_cnt = 4'd8;
			end
			default: begin
				mask     = 64'hFFFF_FFFF_FFFF_FFFF;
				size_cnt = 4'd8;
			end
		endcase
	end

	// select the patch
	always_comb begin
		res.new_bytes     = old_bytes;
		res.bytes_written = 4'd0;
		res.range_error   = 1'b0;
		res.unsupported   = 1'b0;
		wide              = 64'd0;
		unique case (dec.op)
			OP_W32: begin
				res.new_bytes     = {w1, value};
				res.bytes_written = 4'd4;
			end
			OP_W64: begin
				res.new_bytes     = sv;
				res.bytes_written = 4'd8;
			end
			OP_U: begin
				if (upper_ok) begin
					res.new_bytes     = {w1, put_u(w0, value)};
					res.bytes_written = 4'd4;
				end else begin
					res.range_error = 1'b1;
				end
			end
			OP_I: begin
				res.new_bytes     = {w1, put_i(w0, value)};
				res.bytes_written = 4'd4;
			end
			OP_S: begin
				res.new_bytes     = {w1, put_s(w0, value)};
				res.bytes_written = 4'd4;
			end
			OP_B: begin
				if (fits13) begin
					res.new_bytes     = {w1, put_b(w0, value)};
					res.bytes_written = 4'd4;
				end else begin
					res.range_error = 1'b1;
				end
			end
			OP_J: begin
				if (fits21) begin
					res.new_bytes     = {w1, put_j(w0, value)};
					res.bytes_written = 4'd4;
				end else begin
					res.range_error = 1'b1;
				end
			end
			OP_CB: begin
				if (fits9) begin
					res.new_bytes     = {old_bytes[63:16], put_cb(old_bytes[15:0], value)};
					res.bytes_written = 4'd2;
				end else begin
					res.range_error = 1'b1;
				end
			end
			OP_CJ: begin
				if (fits12) begin
					res.new_bytes     = {old_bytes[63:16], put_cj(old_bytes[15:0], value)};
					res.bytes_written = 4'd2;
				end else begin
					res.range_error = 1'b1;
				end
			end
			OP_CALL: begin
				if (upper_ok) begin
					res.new_bytes     = {put_i(w1, value), put_u(w0, value)};
					res.bytes_written = 4'd8;
				end else begin
					res.range_error = 1'b1;
				end
			end
			OP_ADD: begin
				res.new_bytes     = (old_bytes & ~mask) | (sum & mask);
				res.bytes_written = size_cnt;
			end
			OP_SUB: begin
				res.new_bytes     = (old_bytes & ~mask) | (diff & mask);
				res.bytes_written = size_cnt;
			end
			OP_SUB6: begin
				res.new_bytes     = {old_bytes[63:6], low6};
				res.bytes_written = 4'd1;
			end
			OP_SET6: begin
				res.new_bytes     = {old_bytes[63:6], value[5:0]};
				res.bytes_written = 4'd1;
			end
			OP_SET: begin
				wide              = {32'd0, value};
				res.new_bytes     = (old_bytes & ~mask) | (wide & mask);
				res.bytes_written = size_cnt;
			end
			OP_NOP: begin
				res.bytes_written = 4'd0;
			end
			OP_UNSUP: begin
				res.unsupported = 1'b1;
			end
			default: begin
				res.unsupported = 1'b1;
			end
		endcase
	end

endmodule

// ----- hw/rtl/riscv_relocation_patcher.sv -----
// ----------------------------------------------------------------------------
// riscv_relocation_patcher
// Applies one RISC-V ELF relocation to eight little-endian memory bytes.
// ----------------------------------------------------------------------------
// The block takes one relocation beat per clock and returns one result beat
// for each, in order. A taken beat is registered in the input register, then
// the decode and patch logic feeds the result register. Both registers advance
// together whenever the result register is empty or its beat is taken, so with
// out_stall low the rate is one beat per cycle; out_stall holds the pipeline
// and raises in_stall once the input register is also full. Range failures
// and unknown types return the old bytes unchanged with the matching flag set.
module riscv_relocation_patcher
	import rrp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         reloc_kind,
	input  logic [63:0]        old_bytes,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [63:0]        new_bytes,
	output logic [3:0]         bytes_written,
	output logic               range_error,
	output logic               unsupported
);

	logic        valid_s1;
	logic [7:0]  kind_s1;
	logic [63:0] old_s1;
	logic [31:0] value_s1;
	logic        valid_s2;
	res_t        res_s2;
	logic        adv;
	logic        take;
	dec_t        dec;
	res_t        res;

	// advance both stages when the result slot is free or being taken
	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign take     = in_valid && !in_stall;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1  <= reloc_kind;
			old_s1   <= old_bytes;
			value_s1 <= value;
		end
	end

	rrp_decode u_decode (
		.reloc_kind (kind_s1),
		.dec        (dec)
	);

	rrp_patch u_patch (
		.dec       (dec),
		.old_bytes (old_s1),
		.value     (value_s1),
		.res       (res)
	);

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign new_bytes     = res_s2.new_bytes;
	assign bytes_written = res_s2.bytes_written;
	assign range_error   = res_s2.range_error;
	assign unsupported   = res_s2.unsupported;

endmodule

// ----- hw/rtl/rrp_checker.sv -----
// ----------------------------------------------------------------------------
// rrp_checker
// Port-level checks on the relocation patcher's result channel.
// ----------------------------------------------------------------------------
module rrp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [7:0]         reloc_kind,
	input logic [63:0]        old_bytes,
	input logic signed [31:0] value,
	input logic               out_valid,
	input logic               out_stall,
	input logic [63:0]        new_bytes,
	input logic [3:0]         bytes_written,
	input logic               range_error,
	input logic               unsupported
);

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(new_bytes)
			&& $stable(bytes_written) && $stable(range_error) && $stable(unsupported))
		else $error("stalled result beat changed");

	// a range failure and an unknown type never come together
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(range_error && unsupported))
		else $error("both error flags set");

	// a flagged beat modifies no bytes
	a_noop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (range_error || unsupported) |-> bytes_written == 4'd0)
		else $error("flagged beat reports written bytes");

	// byte count is one of the legal widths
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bytes_written == 4'd0 || bytes_written == 4'd1
			|| bytes_written == 4'd2 || bytes_written == 4'd4 || bytes_written == 4'd8)
		else $error("illegal byte count");

endmodule

bind riscv_relocation_patcher rrp_checker u_rrp_checker (.*);

// ----- test/riscv_relocation_patcher_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// riscv_relocation_patcher_checker
// Predicts and compares the patched bytes for each relocation beat.
// Watches both channels of the patcher. Every accepted relocation beat gets
// its patched bytes and flags worked out and queued; every accepted result
// beat is compared field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module riscv_relocation_patcher_checker
	import rrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  reloc_kind,
	input  logic [63:0] old_bytes,
	input  logic [31:0] value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] new_bytes,
	input  logic [3:0]  bytes_written,
	input  logic        range_error,
	input  logic        unsupported,
	output int          mismatches,
	output int          pending
);

	res_t patch_q[$];
	res_t want;
	int   mismatch_cnt = 0;
	int   pending_cnt = 0;

	assign mismatches = mismatch_cnt;
	assign pending = pending_cnt;

	// true when v fits an n-bit signed immediate
	function automatic logic fits_signed(logic [31:0] v, int n);
		int sv;
		int lim;
		sv = $signed(v);
		lim = 1 << (n - 1);
		return (sv >= -lim) && (sv < lim);
	endfunction

	// upper 20 bits with rounding for the low 12-bit partner
	function automatic logic [31:0] hi20_insn(logic [31:0] insn, logic [31:0] v);
		logic [31:0] rounded;
		rounded = v + 32'h800;
		return {rounded[31:12], insn[11:0]};
	endfunction

	function automatic logic [31:0] lo12_insn(logic [31:0] insn, logic [31:0] v);
		return {v[11:0], insn[19:0]};
	endfunction

	// patched memory and flags for one relocation
	function automatic res_t patch_relocation(logic [7:0] kind, logic [63:0] mem,
			logic [31:0] v);
		res_t        r;
		logic [63:0] sv;
		logic [31:0] w0;
		logic [31:0] w1;
		logic        upper_fits;
		sv = {{32{v[31]}}, v};
		w0 = mem[31:0];
		w1 = mem[63:32];
		// U-type rounding overflows from 0x7FFFF800 up
		upper_fits = ($signed(v) < $signed(32'h7FFFF800));
		r.new_bytes = mem;
		r.bytes_written = 4'd0;
		r.range_error = 1'b0;
		r.unsupported = 1'b0;
		case (kind)
			R_32, R_32_PCREL, R_SET32: begin
				r.new_bytes[31:0] = v;
				r.bytes_written = 4'd4;
			end
			R_64: begin
				r.new_bytes = sv;
				r.bytes_written = 4'd8;
			end
			R_GOT_HI20, R_PCREL_HI20, R_HI20: begin
				if (!upper_fits) begin
					r.range_error = 1'b1;
				end else begin
					r.new_bytes[31:0] = hi20_insn(w0, v);
					r.bytes_written = 4'd4;
				end
			end
			R_PCREL_LO12_I, R_LO12_I: begin
				r.new_bytes[31:0] = lo12_insn(w0, v);
				r.bytes_written = 4'd4;
			end
			R_PCREL_LO12_S, R_LO12_S, R_TPREL_LO12_S: begin
				r.new_bytes[31:0] = {v[11:5], w0[24:12], v[4:0], w0[6:0]};
				r.bytes_written = 4'd4;
			end
			// branch and jump offsets drop bit 0 without a check
			R_BRANCH: begin
				if (!fits_signed(v, 13)) begin
					r.range_error = 1'b1;
				end else begin
					r.new_bytes[31:0] = {v[12], v[10:5], w0[24:12], v[4:1], v[11],
						w0[6:0]};
					r.bytes_written = 4'd4;
				end
			end
			R_JAL: begin
				if (!fits_signed(v, 21)) begin
					r.range_error = 1'b1;
				end else begin
					r.new_bytes[31:0] = {v[20], v[10:1], v[11], v[19:12], w0[11:0]};
					r.bytes_written = 4'd4;
				end
			end
			R_RVC_BRANCH: begin
				if (!fits_signed(v, 9)) begin
					r.range_error = 1'b1;
				end else begin
					r.new_bytes[15:0] = {w0[15:13], v[8], v[4:3], w0[9:7], v[7:6],
						v[2:1], v[5], w0[1:0]};
					r.bytes_written = 4'd2;
				end
			end
			R_RVC_JUMP: begin
				if (!fits_signed(v, 12)) begin
					r.range_error = 1'b1;
				end else begin
					r.new_bytes[15:0] = {w0[15:13], v[11], v[4], v[9:8], v[10], v[6],
						v[7], v[3:1], v[5], w0[1:0]};
					r.bytes_written = 4'd2;
				end
			end
			// auipc + jalr pair: neither word changes on overflow
			R_CALL, R_CALL_PLT: begin
				if (!upper_fits) begin
					r.range_error = 1'b1;
				end else begin
					r.new_bytes = {lo12_insn(w1, v), hi20_insn(w0, v)};
					r.bytes_written = 4'd8;
				end
			end
			R_ADD8: begin
				r.new_bytes[7:0] = mem[7:0] + sv[7:0];
				r.bytes_written = 4'd1;
			end
			R_ADD16: begin
				r.new_bytes[15:0] = mem[15:0] + sv[15:0];
				r.bytes_written = 4'd2;
			end
			R_ADD32: begin
				r.new_bytes[31:0] = mem[31:0] + sv[31:0];
				r.bytes_written = 4'd4;
			end
			R_ADD64: begin
				r.new_bytes = mem + sv;
				r.bytes_written = 4'd8;
			end
			R_SUB8: begin
				r.new_bytes[7:0] = mem[7:0] - sv[7:0];
				r.bytes_written = 4'd1;
			end
			R_SUB16: begin
				r.new_bytes[15:0] = mem[15:0] - sv[15:0];
				r.bytes_written = 4'd2;
			end
			R_SUB32: begin
				r.new_bytes[31:0] = mem[31:0] - sv[31:0];
				r.bytes_written = 4'd4;
			end
			R_SUB64: begin
				r.new_bytes = mem - sv;
				r.bytes_written = 4'd8;
			end
			// 6-bit fields keep bits 7:6 of byte 0
			R_SUB6: begin
				r.new_bytes[5:0] = mem[5:0] - v[5:0];
				r.bytes_written = 4'd1;
			end
			R_SET6: begin
				r.new_bytes[5:0] = v[5:0];
				r.bytes_written = 4'd1;
			end
			R_SET8: begin
				r.new_bytes[7:0] = v[7:0];
				r.bytes_written = 4'd1;
			end
			R_SET16: begin
				r.new_bytes[15:0] = v[15:0];
				r.bytes_written = 4'd2;
			end
			R_ALIGN, R_RELAX: begin
			end
			default: begin
				r.unsupported = 1'b1;
			end
		endcase
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] expv, logic [63:0] actv);
		if (expv !== actv) begin
			$display("%0t: %s expected %h, got %h", $time, name, expv, actv);
			mismatch_cnt++;
		end
	endtask

	// compare the result beat, then queue the prediction for the input beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			patch_q.delete();
			pending_cnt = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (patch_q.size() == 0) begin
					$display("%0t: unexpected result beat, new_bytes %h", $time,
						new_bytes);
					mismatch_cnt++;
				end else begin
					want = patch_q.pop_front();
					check_field("new_bytes", want.new_bytes, new_bytes);
					check_field("bytes_written", 64'(want.bytes_written),
						64'(bytes_written));
					check_field("range_error", 64'(want.range_error), 64'(range_error));
					check_field("unsupported", 64'(want.unsupported), 64'(unsupported));
				end
			end
			if (in_valid && !in_stall) begin
				patch_q.push_back(patch_relocation(reloc_kind, old_bytes, value));
			end
			pending_cnt = patch_q.size();
		end
	end

endmodule

// ----- test/riscv_relocation_patcher_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// riscv_relocation_patcher_tb
// Stimulus and verdict for the relocation patcher.
// Sends directed relocations over field extremes, range edges and unknown
// types, then random relocations under several sender and receiver idling
// patterns. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module riscv_relocation_patcher_tb;
	import rrp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_BEATS = 390;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  reloc_kind;
	logic [63:0] old_bytes;
	logic [31:0] value;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] new_bytes;
	logic [3:0]  bytes_written;
	logic        range_error;
	logic        unsupported;
	int          mismatches;
	int          pending;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          quiet_cycles = 0;

	logic [7:0] handled_kinds [32] = '{
		R_32, R_64, R_BRANCH, R_JAL, R_CALL, R_CALL_PLT, R_GOT_HI20, R_PCREL_HI20,
		R_PCREL_LO12_I, R_PCREL_LO12_S, R_HI20, R_LO12_I, R_LO12_S, R_TPREL_LO12_S,
		R_ADD8, R_ADD16, R_ADD32, R_ADD64, R_SUB8, R_SUB16, R_SUB32, R_SUB64,
		R_ALIGN, R_RVC_BRANCH, R_RVC_JUMP, R_RELAX, R_SUB6, R_SET6, R_SET8,
		R_SET16, R_SET32, R_32_PCREL
	};

	riscv_relocation_patcher u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.reloc_kind    (reloc_kind),
		.old_bytes     (old_bytes),
		.value         (value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.new_bytes     (new_bytes),
		.bytes_written (bytes_written),
		.range_error   (range_error),
		.unsupported   (unsupported)
	);

	riscv_relocation_patcher_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.reloc_kind    (reloc_kind),
		.old_bytes     (old_bytes),
		.value         (value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.new_bytes     (new_bytes),
		.bytes_written (bytes_written),
		.range_error   (range_error),
		.unsupported   (unsupported),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	always #2 clk = ~clk;

	// randomly stall the result channel
	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	// end the run when no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// hold one relocation beat until it is taken
	task automatic send_beat(logic [7:0] kind, logic [63:0] mem, logic [31:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		reloc_kind <= kind;
		old_bytes <= mem;
		value <= v;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// pause the sender until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	// bias values toward immediate range edges and the upper rounding limit
	function automatic logic [31:0] pick_value();
		int bound;
		case ($urandom_range(4))
			0: return $urandom();
			1: return int'($urandom_range(8191)) - 4096;
			2: begin
				case ($urandom_range(3))
					0: bound = 1 << 8;
					1: bound = 1 << 11;
					2: bound = 1 << 12;
					default: bound = 1 << 20;
				endcase
				if ($urandom_range(1)) bound = -bound;
				return bound + int'($urandom_range(2)) - 1;
			end
			3: return 32'h7FFFF800 + int'($urandom_range(4)) - 2;
			default: return int'($urandom_range(2097151)) - 1048576;
		endcase
	endfunction

	task automatic send_random_beat();
		logic [7:0]  kind;
		logic [63:0] mem;
		if ($urandom_range(99) < 8) kind = 8'($urandom_range(255));
		else kind = handled_kinds[$urandom_range(31)];
		case ($urandom_range(19))
			0: mem = '0;
			1: mem = '1;
			default: mem = {$urandom(), $urandom()};
		endcase
		send_beat(kind, mem, pick_value());
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		reloc_kind = '0;
		old_bytes = '0;
		value = '0;
		out_stall = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: field extremes, range edges, no-op and unknown types
		send_beat(R_32, '1, 32'h80000000);
		send_beat(R_64, '0, 32'hFFFFFFFF);
		send_beat(R_HI20, 64'h0123456789ABCDEF, 32'h7FFFF7FF);
		send_beat(R_PCREL_HI20, 64'h0123456789ABCDEF, 32'h7FFFF800);
		send_beat(R_LO12_I, '0, 32'hFFFFFFFF);
		send_beat(R_LO12_S, '1, 32'h7FFFFFFF);
		send_beat(R_BRANCH, 64'hFEDCBA9876543210, 32'd4095);
		send_beat(R_BRANCH, 64'hFEDCBA9876543210, 32'd4096);
		send_beat(R_JAL, '1, -32'sd1048576);
		send_beat(R_RVC_BRANCH, '1, -32'sd256);
		send_beat(R_RVC_BRANCH, '1, 32'd256);
		send_beat(R_RVC_JUMP, '0, 32'd2047);
		send_beat(R_CALL, '1, 32'h80000000);
		send_beat(R_CALL_PLT, '1, 32'h7FFFFFFF);
		send_beat(R_ADD64, '1, 32'd1);
		send_beat(R_ADD8, '0, 32'hFFFFFFFF);
		send_beat(R_SUB16, 64'h00000000000000FF, 32'h80000000);
		send_beat(R_SUB6, 64'h00000000000000C0, 32'd1);
		send_beat(R_SET6, '1, 32'd0);
		send_beat(R_SET16, '0, 32'hFFFF1234);
		send_beat(R_ALIGN, 64'h5555AAAA5555AAAA, 32'h12345678);
		send_beat(R_RELAX, 64'hAAAA5555AAAA5555, 32'h87654321);
		send_beat(8'd0, '1, 32'hFFFFFFFF);
		send_beat(8'd255, '0, 32'h00000000);
		drain();

		// random: no idling, sender idle, receiver stalling, then both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 75; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 75; end
				default: begin send_idle_pct = 14; stall_pct = 14; end
			endcase
			repeat (RANDOM_BEATS) send_random_beat();
			drain();
		end

		// allow for stray beats to show up before the verdict
		repeat (8) @(negedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/rrp_pkg.sv
hw/rtl/rrp_decode.sv
hw/rtl/rrp_patch.sv
hw/rtl/riscv_relocation_patcher.sv
hw/rtl/rrp_checker.sv
test/riscv_relocation_patcher_checker.sv
test/riscv_relocation_patcher_tb.sv
